FILE: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

FILE: rtl/core/tfcm_pkg.sv
package tfcm_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int KNOT_MAX = 7;
    localparam int KIDX_W   = 3;
    localparam int CNT_W    = 3;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int COLOR_W  = CHAN_W * NUM_CHAN;

    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_SHIFT = 3;

    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [COLOR_W-1:0] color_t;

    localparam count_t COUNT_RESET = count_t'(1);

    typedef enum logic [PADDR_W-REG_SHIFT-1:0] {
        REG_KNOT_COUNT,
        REG_KNOT_0,
        REG_KNOT_1,
        REG_KNOT_2,
        REG_KNOT_3,
        REG_KNOT_4,
        REG_KNOT_5,
        REG_KNOT_6
    } reg_idx_t;

endpackage

FILE: rtl/core/tfcm_cfg.sv
module tfcm_cfg #(
    parameter int SAMPLE_BITS = tfcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  psel,
    input  logic                                                  penable,
    input  logic                                                  pwrite,
    input  logic [tfcm_pkg::PADDR_W-1:0]                          paddr,
    input  logic [tfcm_pkg::PDATA_W-1:0]                          pwdata,
    output logic [tfcm_pkg::PDATA_W-1:0]                          prdata,
    output tfcm_pkg::count_t                                      knot_count,
    output logic [tfcm_pkg::KNOT_MAX-1:0][tfcm_pkg::COLOR_W+SAMPLE_BITS-1:0] knots
);
    import tfcm_pkg::*;

    localparam int KNOT_W = COLOR_W + SAMPLE_BITS;

    reg_idx_t                              idx;
    logic                                  wr;
    logic [KIDX_W-1:0]                     ksel;
    count_t                                count_reg;
    logic [KNOT_MAX-1:0][KNOT_W-1:0]       knot_reg;

    assign idx  = reg_idx_t'(paddr[PADDR_W-1:REG_SHIFT]);
    assign wr   = psel & penable & pwrite;
    assign ksel = KIDX_W'(idx) - KIDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
            knot_reg  <= '0;
        end else if (wr) begin
            if (idx == REG_KNOT_COUNT) begin
                count_reg <= pwdata[CNT_W-1:0];
            end else begin
                knot_reg[ksel] <= pwdata[KNOT_W-1:0];
            end
        end
    end

    always_comb begin
        if (idx == REG_KNOT_COUNT) begin
            prdata = PDATA_W'(count_reg);
        end else begin
            prdata = PDATA_W'(knot_reg[ksel]);
        end
    end

    assign knot_count = count_reg;
    assign knots      = knot_reg;

endmodule

FILE: rtl/core/tfcm_seg.sv
module tfcm_seg #(
    parameter int SAMPLE_BITS = tfcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tfcm_pkg::count_t                       knot_count,
    input  logic [tfcm_pkg::KNOT_MAX-1:0][tfcm_pkg::COLOR_W+SAMPLE_BITS-1:0] knots,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_BITS-1:0]          in_value,
    input  logic                                   in_invalid,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [SAMPLE_BITS-1:0]                 out_num,
    output logic [SAMPLE_BITS-1:0]                 out_den,
    output tfcm_pkg::color_t                       out_ca,
    output tfcm_pkg::color_t                       out_cb
);
    import tfcm_pkg::*;

    typedef enum logic [1:0] {
        SEG_ZERO,
        SEG_FIRST,
        SEG_LAST,
        SEG_INTERP
    } seg_mode_t;

    logic signed [SAMPLE_BITS-1:0] kv [KNOT_MAX];
    logic [KIDX_W-1:0]             last;
    logic [KIDX_W-1:0]             hi_scan;

    seg_mode_t                     mode_next, mode_reg;
    logic [KIDX_W-1:0]             lo_next, hi_next, lo_reg, hi_reg;
    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic                          vld1_reg, vld2_reg;
    logic                          en1, en2;

    logic signed [SAMPLE_BITS-1:0] a, b;
    logic [SAMPLE_BITS-1:0]        num_next, den_next, num_reg, den_reg;
    color_t                        ca_next, cb_next, ca_reg, cb_reg;

    assign en2      = !vld2_reg || out_ready;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    // stage 1: knot compares and segment pick
    always_comb begin
        for (int i = 0; i < KNOT_MAX; i++) begin
            kv[i] = $signed(knots[i][COLOR_W +: SAMPLE_BITS]);
        end
        last    = (knot_count == '0) ? '0 : knot_count - count_t'(1);
        hi_scan = last;
        for (int i = KNOT_MAX - 1; i >= 1; i--) begin
            if (KIDX_W'(i) <= last && kv[i] > in_value) begin
                hi_scan = KIDX_W'(i);
            end
        end
        if (in_invalid) begin
            mode_next = SEG_ZERO;
            lo_next   = '0;
            hi_next   = '0;
        end else if (in_value <= kv[0]) begin
            mode_next = SEG_FIRST;
            lo_next   = '0;
            hi_next   = '0;
        end else if (in_value >= kv[last]) begin
            mode_next = SEG_LAST;
            lo_next   = last;
            hi_next   = last;
        end else begin
            mode_next = SEG_INTERP;
            lo_next   = hi_scan - KIDX_W'(1);
            hi_next   = hi_scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en1) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mode_reg <= mode_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            v_reg    <= in_value;
        end
    end

    // stage 2: endpoint fetch and differences
    always_comb begin
        a       = kv[lo_reg];
        b       = kv[hi_reg];
        ca_next = knots[lo_reg][COLOR_W-1:0];
        cb_next = knots[hi_reg][COLOR_W-1:0];
        if (mode_reg == SEG_ZERO) begin
            ca_next = '0;
            cb_next = '0;
        end
        if (mode_reg == SEG_INTERP) begin
            num_next = SAMPLE_BITS'(v_reg - a);
            den_next = SAMPLE_BITS'(b - a);
        end else begin
            num_next = '0;
            den_next = SAMPLE_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en2) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            num_reg <= num_next;
            den_reg <= den_next;
            ca_reg  <= ca_next;
            cb_reg  <= cb_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_ca    = ca_reg;
    assign out_cb    = cb_reg;

endmodule

FILE: rtl/core/tfcm_div.sv
module tfcm_div #(
    parameter int SAMPLE_BITS   = tfcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = tfcm_pkg::FRACTION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   in_num,
    input  logic [SAMPLE_BITS-1:0]   in_den,
    input  tfcm_pkg::color_t         in_ca,
    input  tfcm_pkg::color_t         in_cb,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRACTION_BITS-1:0] out_t,
    output tfcm_pkg::color_t         out_ca,
    output tfcm_pkg::color_t         out_cb
);
    import tfcm_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;

    // restoring division, one quotient bit per stage; num < den always
    logic [SB-1:0] r_reg  [FB];
    logic [SB-1:0] d_reg  [FB];
    logic [FB-1:0] q_reg  [FB];
    color_t        ca_reg [FB];
    color_t        cb_reg [FB];
    logic          vld_reg [FB];
    logic [FB-1:0] en;

    always_comb begin
        en[FB-1] = !vld_reg[FB-1] || out_ready;
        for (int j = FB - 2; j >= 0; j--) begin
            en[j] = !vld_reg[j] || en[j+1];
        end
    end

    assign in_ready = en[0];

    genvar k;
    generate
        for (k = 0; k < FB; k++) begin : g_stage
            logic [SB-1:0] r_in, d_in, r_next;
            logic [FB-1:0] q_in;
            color_t        ca_in, cb_in;
            logic          v_in;
            logic [SB:0]   r2, r2_sub;
            logic          ge;

            if (k == 0) begin : g_first
                assign r_in  = in_num;
                assign d_in  = in_den;
                assign q_in  = '0;
                assign ca_in = in_ca;
                assign cb_in = in_cb;
                assign v_in  = in_valid;
            end else begin : g_rest
                assign r_in  = r_reg[k-1];
                assign d_in  = d_reg[k-1];
                assign q_in  = q_reg[k-1];
                assign ca_in = ca_reg[k-1];
                assign cb_in = cb_reg[k-1];
                assign v_in  = vld_reg[k-1];
            end

            assign r2     = {r_in, 1'b0};
            assign ge     = r2 >= {1'b0, d_in};
            assign r2_sub = r2 - {1'b0, d_in};
            assign r_next = ge ? r2_sub[SB-1:0] : r2[SB-1:0];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en[k]) begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    r_reg[k]  <= r_next;
                    d_reg[k]  <= d_in;
                    q_reg[k]  <= {q_in[FB-2:0], ge};
                    ca_reg[k] <= ca_in;
                    cb_reg[k] <= cb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[FB-1];
    assign out_t     = q_reg[FB-1];
    assign out_ca    = ca_reg[FB-1];
    assign out_cb    = cb_reg[FB-1];

endmodule

FILE: rtl/core/tfcm_blend.sv
module tfcm_blend #(
    parameter int FRACTION_BITS = tfcm_pkg::FRACTION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FRACTION_BITS-1:0] in_t,
    input  tfcm_pkg::color_t         in_ca,
    input  tfcm_pkg::color_t         in_cb,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tfcm_pkg::color_t         out_rgba
);
    import tfcm_pkg::*;

    localparam int FB  = FRACTION_BITS;
    localparam int PW  = FB + CHAN_W + 2;
    localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);

    // color = ca + (cb - ca) * t, rounded
    logic signed [PW-1:0] prod_next [NUM_CHAN];
    logic signed [PW-1:0] prod_reg  [NUM_CHAN];
    color_t               ca_reg;
    color_t               rgba_next, rgba_reg;
    logic                 vld_m_reg, vld_o_reg;
    logic                 en_m, en_o;

    assign en_o     = !vld_o_reg || out_ready;
    assign en_m     = !vld_m_reg || en_o;
    assign in_ready = en_m;

    always_comb begin
        logic signed [CHAN_W:0] dc;
        logic signed [FB:0]     tt;
        tt = $signed({1'b0, in_t});
        for (int c = 0; c < NUM_CHAN; c++) begin
            dc = $signed({1'b0, in_cb[COLOR_W-1-CHAN_W*c -: CHAN_W]})
               - $signed({1'b0, in_ca[COLOR_W-1-CHAN_W*c -: CHAN_W]});
            prod_next[c] = dc * tt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_m_reg <= 1'b0;
        end else if (en_m) begin
            vld_m_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_m) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                prod_reg[c] <= prod_next[c];
            end
            ca_reg <= in_ca;
        end
    end

    always_comb begin
        logic signed [PW-1:0] s;
        for (int c = 0; c < NUM_CHAN; c++) begin
            s = $signed({2'b00, ca_reg[COLOR_W-1-CHAN_W*c -: CHAN_W], {FB{1'b0}}})
              + prod_reg[c] + $signed(HALF);
            rgba_next[COLOR_W-1-CHAN_W*c -: CHAN_W] = s[FB +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg <= 1'b0;
        end else if (en_o) begin
            vld_o_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o) begin
            rgba_reg <= rgba_next;
        end
    end

    assign out_valid = vld_o_reg;
    assign out_rgba  = rgba_reg;

endmodule

FILE: rtl/core/transfer_function_color_map_unit.sv
// Piecewise-linear transfer function: maps a signed sample to RGBA through
// up to seven knots held in registers (knot_count at 0x00, knot_0..knot_6
// at 0x08..0x38, 64-bit data, value in the bits above the color bytes).
// Input channel s_*: one sample per transfer, s_sample_invalid forces black.
// Output channel m_*: one RGBA result per transfer, in input order.
// Path from input transfer to m_valid: two segment-select stages, one
// restoring divider stage per fraction bit, a multiply stage and the
// output register.
// Throughput: one sample per cycle when m_ready stays high.
// Stall: each stage holds while the stage after it is full, so a bubble
// anywhere lets s_ready stay high; with the whole pipe full and m_ready low,
// s_ready drops and nothing is lost or repeated.
// Reset (aresetn low, synchronous): pipeline emptied, knot_count = 1,
// all knots zero. pready is always high; write knots only while idle.
module transfer_function_color_map_unit #(
    parameter int SAMPLE_BITS   = tfcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = tfcm_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfcm_pkg::PADDR_W-1:0]    paddr,
    input  logic [tfcm_pkg::PDATA_W-1:0]    pwdata,
    output logic [tfcm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample_value,
    input  logic                            s_sample_invalid,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tfcm_pkg::CHAN_W-1:0]     m_red,
    output logic [tfcm_pkg::CHAN_W-1:0]     m_green,
    output logic [tfcm_pkg::CHAN_W-1:0]     m_blue,
    output logic [tfcm_pkg::CHAN_W-1:0]     m_alpha
);
    import tfcm_pkg::*;

    count_t                                       knot_count;
    logic [KNOT_MAX-1:0][COLOR_W+SAMPLE_BITS-1:0] knots;

    logic                     seg_valid, seg_ready;
    logic [SAMPLE_BITS-1:0]   seg_num, seg_den;
    color_t                   seg_ca, seg_cb;

    logic                     div_valid, div_ready;
    logic [FRACTION_BITS-1:0] div_t;
    color_t                   div_ca, div_cb;

    color_t                   rgba;

    assign pready = 1'b1;

    tfcm_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .knot_count (knot_count),
        .knots      (knots)
    );

    tfcm_seg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .knot_count (knot_count),
        .knots      (knots),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_value   (s_sample_value),
        .in_invalid (s_sample_invalid),
        .out_valid  (seg_valid),
        .out_ready  (seg_ready),
        .out_num    (seg_num),
        .out_den    (seg_den),
        .out_ca     (seg_ca),
        .out_cb     (seg_cb)
    );

    tfcm_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_num    (seg_num),
        .in_den    (seg_den),
        .in_ca     (seg_ca),
        .in_cb     (seg_cb),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_t     (div_t),
        .out_ca    (div_ca),
        .out_cb    (div_cb)
    );

    tfcm_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_t      (div_t),
        .in_ca     (div_ca),
        .in_cb     (div_cb),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rgba  (rgba)
    );

    assign m_red   = rgba[COLOR_W-1 -: CHAN_W];
    assign m_green = rgba[COLOR_W-1-CHAN_W -: CHAN_W];
    assign m_blue  = rgba[COLOR_W-1-2*CHAN_W -: CHAN_W];
    assign m_alpha = rgba[CHAN_W-1:0];

endmodule

FILE: rtl/core/tfcm_checker.sv
`include "assert_macros.svh"

module tfcm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tfcm_pkg::CHAN_W-1:0] m_red,
    input logic [tfcm_pkg::CHAN_W-1:0] m_green,
    input logic [tfcm_pkg::CHAN_W-1:0] m_blue,
    input logic [tfcm_pkg::CHAN_W-1:0] m_alpha
);

    `ASSERT_CLK_NR(a_reset_empties, aclk, !aresetn |=> !m_valid)

    `ASSERT_CLK(a_empty_takes_input, aclk, aresetn, !m_valid |-> s_ready)

    `ASSERT_CLK(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green) && $stable(m_blue) && $stable(m_alpha))

    `ASSERT_CLK(a_pready_high, aclk, aresetn, pready)

endmodule

bind transfer_function_color_map_unit tfcm_checker u_tfcm_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import tfcm_pkg::*;

    localparam int SBITS    = SAMPLE_BITS_DEF;
    localparam int FBITS    = FRACTION_BITS_DEF;
    localparam int LATENCY  = FBITS + 4;
    localparam int TAIL     = 2 * LATENCY + 8;
    localparam int MAX_SHOW = 10;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [SBITS-1:0]  s_sample_value = '0;
    logic                     s_sample_invalid = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [CHAN_W-1:0]        m_red;
    logic [CHAN_W-1:0]        m_green;
    logic [CHAN_W-1:0]        m_blue;
    logic [CHAN_W-1:0]        m_alpha;

    // local copy of the transfer function registers
    count_t      tf_count;
    logic [47:0] tf_knot [KNOT_MAX];

    color_t expected_colors [$];
    int     mismatch_count = 0;
    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;
    int     rx_hold_len = 0;

    transfer_function_color_map_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .s_sample_invalid (s_sample_invalid),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_alpha          (m_alpha)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[transfer_function_color_map_unit] ERROR");
        $finish;
    end

    function automatic longint knot_val(int i);
        return longint'($signed(tf_knot[i][32 +: SBITS]));
    endfunction

    function automatic color_t map_sample(logic signed [SBITS-1:0] v, logic inv);
        int          n;
        int          last;
        int          hi;
        longint      vv;
        longint      a;
        longint      b;
        longint      t;
        longint      s;
        color_t      lo_c;
        color_t      hi_c;
        color_t      res;
        if (inv)
            return '0;
        n = int'(tf_count);
        if (n == 0)
            n = 1;
        last = n - 1;
        vv = v;
        if (vv <= knot_val(0))
            return tf_knot[0][31:0];
        if (vv >= knot_val(last))
            return tf_knot[last][31:0];
        hi = last;
        for (int i = 1; i <= last; i++) begin
            if (knot_val(i) > vv) begin
                hi = i;
                break;
            end
        end
        a = knot_val(hi - 1);
        b = knot_val(hi);
        t = ((vv - a) << FBITS) / (b - a);
        lo_c = tf_knot[hi - 1][31:0];
        hi_c = tf_knot[hi][31:0];
        for (int c = 0; c < NUM_CHAN; c++) begin
            s = longint'(lo_c[c*CHAN_W +: CHAN_W]) * ((64'sd1 << FBITS) - t)
                + longint'(hi_c[c*CHAN_W +: CHAN_W]) * t + (64'sd1 << (FBITS - 1));
            res[c*CHAN_W +: CHAN_W] = s[FBITS +: CHAN_W];
        end
        return res;
    endfunction

    // input side: predict on every accepted sample
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_colors.insert(expected_colors.size(),
                                   map_sample(s_sample_value, s_sample_invalid));
    end

    // output side: compare every accepted result against the oldest prediction
    always @(posedge aclk) begin
        color_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOW)
                    $display("%0t: result with no prediction: %h", $time,
                             {m_red, m_green, m_blue, m_alpha});
            end else begin
                exp_c = expected_colors.pop_front();
                if (m_red !== exp_c[31:24] || m_green !== exp_c[23:16] ||
                    m_blue !== exp_c[15:8] || m_alpha !== exp_c[7:0]) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOW)
                        $display("%0t: rgba expected %h got %h", $time, exp_c,
                                 {m_red, m_green, m_blue, m_alpha});
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold when requested
    always begin
        @(negedge aclk);
        if (rx_hold_len > 0) begin
            m_ready = 1'b0;
            repeat (rx_hold_len - 1) @(negedge aclk);
            rx_hold_len = 0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            m_ready = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
        end else begin
            m_ready = 1'b1;
        end
    end

    task automatic send_sample(input logic signed [SBITS-1:0] v, input logic inv);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_value = v;
        s_sample_invalid = inv;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_colors.size() != 0)
            @(negedge aclk);
        repeat (TAIL) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_W'(idx) << REG_SHIFT;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_KNOT_COUNT)
            tf_count = data[CNT_W-1:0];
        else
            tf_knot[int'(idx) - 1] = data[47:0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_knot(input int i, input int value, input color_t col);
        logic [15:0] junk;
        logic [15:0] kv;
        junk = 16'($urandom);
        kv = 16'(value);
        write_reg(reg_idx_t'(int'(REG_KNOT_0) + i), {junk, kv, col});
    endtask

    task automatic set_count(input int n);
        logic [PDATA_W-1:0] data;
        data = {$urandom, $urandom};
        data[CNT_W-1:0] = CNT_W'(n);
        write_reg(REG_KNOT_COUNT, data);
    endtask

    task automatic test_reset_state();
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b0);
        send_sample(0, 1'b0);
        send_sample(16'h5a5a, 1'b1);
    endtask

    task automatic test_knot_edges();
        drain();
        set_count(7);
        write_knot(0, -32768, 32'hFF00FF00);
        write_knot(1, -100,   32'h00FFFFFF);
        write_knot(2, -99,    32'hFFFFFFFF);
        write_knot(3, 0,      32'h00000000);
        write_knot(4, 1,      32'hFFFFFFFF);
        write_knot(5, 1000,   32'h12345678);
        write_knot(6, 32767,  32'hFEDCBA98);
        send_sample(-32768, 1'b0);
        send_sample(-32767, 1'b0);
        send_sample(-101, 1'b0);
        send_sample(-100, 1'b0);
        send_sample(-99, 1'b0);
        send_sample(0, 1'b0);
        send_sample(1, 1'b0);
        send_sample(500, 1'b0);
        send_sample(999, 1'b0);
        send_sample(32766, 1'b0);
        send_sample(32767, 1'b0);
        send_sample(32767, 1'b1);
    endtask

    // zero knots in use behaves as one
    task automatic test_count_zero();
        drain();
        set_count(0);
        send_sample(-32768, 1'b0);
        send_sample(5, 1'b0);
        send_sample(32767, 1'b0);
    endtask

    task automatic test_unordered_knots();
        drain();
        set_count(4);
        write_knot(0, 0,   32'h000000FF);
        write_knot(1, 100, 32'hFF00FF00);
        write_knot(2, 50,  32'h00FF00FF);
        write_knot(3, 200, 32'hFFFFFFFF);
        send_sample(25, 1'b0);
        send_sample(75, 1'b0);
        send_sample(150, 1'b0);
        send_sample(199, 1'b0);
    endtask

    // long receiver hold so the pipe fills and s_ready drops
    task automatic test_output_stall();
        drain();
        tx_idle = 1'b0;
        set_count(3);
        write_knot(0, -1000, $urandom);
        write_knot(1, 0,     $urandom);
        write_knot(2, 1000,  $urandom);
        rx_hold_len = 150;
        for (int i = 0; i < 80; i++)
            send_sample(SBITS'(int'($urandom_range(0, 2400)) - 1200),
                        $urandom_range(0, 15) == 0);
        drain();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_maps();
        int kvals [KNOT_MAX];
        int n;
        int lo;
        int hi;
        int mode;
        int tmp;
        int v;
        int items;
        int sel;
        for (int p = 0; p < 11; p++) begin
            drain();
            tx_idle = (p < 9);
            rx_idle = (p < 9);
            mode = p % 4;
            items = (p < 9) ? 150 : 200;
            for (int i = 0; i < KNOT_MAX; i++)
                kvals[i] = int'($urandom_range(0, 65535)) - 32768;
            if (mode == 0) begin
                for (int i = 1; i < KNOT_MAX; i++)
                    for (int j = i; j > 0 && kvals[j] < kvals[j-1]; j--) begin
                        tmp = kvals[j];
                        kvals[j] = kvals[j-1];
                        kvals[j-1] = tmp;
                    end
                for (int i = 1; i < KNOT_MAX; i++)
                    if (kvals[i] <= kvals[i-1] && kvals[i-1] < 32767)
                        kvals[i] = kvals[i-1] + 1;
            end else if (mode == 1) begin
                kvals[0] = int'($urandom_range(0, 65500)) - 32768;
                for (int i = 1; i < KNOT_MAX; i++)
                    kvals[i] = kvals[i-1] + int'($urandom_range(1, 3));
            end else if (mode == 3) begin
                kvals[0] = -32768;
                kvals[1] = 32767;
            end
            n = (mode == 3) ? 2 : ((p == 4) ? 1 : ((p == 8) ? 7 : $urandom_range(0, 7)));
            set_count(n);
            for (int i = 0; i < KNOT_MAX; i++)
                write_knot(i, kvals[i], $urandom);
            if (n == 0)
                n = 1;
            lo = kvals[0];
            hi = kvals[0];
            for (int i = 1; i < n; i++) begin
                if (kvals[i] < lo) lo = kvals[i];
                if (kvals[i] > hi) hi = kvals[i];
            end
            for (int k = 0; k < items; k++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else if (sel <= 2)
                    v = kvals[$urandom_range(0, n - 1)] + int'($urandom_range(0, 4)) - 2;
                else
                    v = lo + int'($urandom_range(0, hi - lo));
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                send_sample(SBITS'(v), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    initial begin
        tf_count = COUNT_RESET;
        for (int i = 0; i < KNOT_MAX; i++)
            tf_knot[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_knot_edges();
        test_count_zero();
        test_unordered_knots();
        test_output_stall();
        test_random_maps();
        drain();
        if (mismatch_count == 0)
            $display("[transfer_function_color_map_unit] OK");
        else
            $display("[transfer_function_color_map_unit] ERROR");
        $finish;
    end

endmodule
